>>> rtl/core/spfr_pkg.sv
// Shared types and constants for the sync-pulse frame receiver.
package spfr_pkg;

  localparam int REG_W = 24;
  localparam int FB_W = 8;
  localparam int IDX_W = 3;
  localparam int TIME_WIDTH_DEF = 24;
  localparam int MAX_FRAME_BITS_DEF = 255;

  localparam logic [REG_W-1:0] SYNC_LENGTH_RST = REG_W'(180000);
  localparam logic [REG_W-1:0] SYNC_MARGIN_RST = REG_W'(200);
  localparam logic [REG_W-1:0] FIRST_DELAY_RST = REG_W'(37500);
  localparam logic [REG_W-1:0] BIT_INTERVAL_RST = REG_W'(14940);
  localparam logic [FB_W-1:0] FRAME_BITS_RST = FB_W'(176);
  localparam logic [REG_W-1:0] HUNT_TIMEOUT_RST = REG_W'(400000);

  typedef enum logic [1:0] {
    EV_SYNC = 2'd0,
    EV_BIT = 2'd1,
    EV_TIMEOUT = 2'd2
  } ev_code_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_SYNC_LENGTH = 3'd0,
    CFG_SYNC_MARGIN = 3'd1,
    CFG_FIRST_DELAY = 3'd2,
    CFG_BIT_INTERVAL = 3'd3,
    CFG_FRAME_BITS = 3'd4,
    CFG_HUNT_TIMEOUT = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    PH_HUNT = 1'b0,
    PH_FRAME = 1'b1
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] sync_length;
    logic [REG_W-1:0] sync_margin;
    logic [REG_W-1:0] first_delay;
    logic [REG_W-1:0] bit_interval;
    logic [FB_W-1:0] frame_bits;
    logic [REG_W-1:0] hunt_timeout;
  } cfg_t;

  typedef struct packed {
    ev_code_t event_res;
    logic bit_value;
    logic repeated_level;
    logic [FB_W-1:0] bit_index;
    logic frame_end;
  } res_t;

endpackage

>>> rtl/core/spfr_in_if.sv
// Input channel: one line level word per handshake.
interface spfr_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

>>> rtl/core/spfr_out_if.sv
// Result channel: one event word per handshake.
interface spfr_out_if;
  logic valid;
  logic ready;
  logic [1:0] event_res;
  logic bit_value;
  logic repeated_level;
  logic [7:0] bit_index;
  logic frame_end;

  modport source (output valid, output event_res, output bit_value,
                  output repeated_level, output bit_index, output frame_end,
                  input ready);
  modport sink (input valid, input event_res, input bit_value,
                input repeated_level, input bit_index, input frame_end,
                output ready);
endinterface

>>> rtl/core/spfr_cfg.sv
// Configuration register bank.
module spfr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [spfr_pkg::IDX_W-1:0]    index,
  input  logic [spfr_pkg::REG_W-1:0]    data,
  output spfr_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_length <= spfr_pkg::SYNC_LENGTH_RST;
      cfg.sync_margin <= spfr_pkg::SYNC_MARGIN_RST;
      cfg.first_delay <= spfr_pkg::FIRST_DELAY_RST;
      cfg.bit_interval <= spfr_pkg::BIT_INTERVAL_RST;
      cfg.frame_bits <= spfr_pkg::FRAME_BITS_RST;
      cfg.hunt_timeout <= spfr_pkg::HUNT_TIMEOUT_RST;
    end else if (we) begin
      unique case (spfr_pkg::cfg_idx_t'(index))
        spfr_pkg::CFG_SYNC_LENGTH:  cfg.sync_length <= data;
        spfr_pkg::CFG_SYNC_MARGIN:  cfg.sync_margin <= data;
        spfr_pkg::CFG_FIRST_DELAY:  cfg.first_delay <= data;
        spfr_pkg::CFG_BIT_INTERVAL: cfg.bit_interval <= data;
        spfr_pkg::CFG_FRAME_BITS:   cfg.frame_bits <= data[spfr_pkg::FB_W-1:0];
        spfr_pkg::CFG_HUNT_TIMEOUT: cfg.hunt_timeout <= data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/spfr_in_stage.sv
// Input register holding one line level word.
module spfr_in_stage (
  input  logic     clk,
  input  logic     rst,
  spfr_in_if.sink  pin_ch,
  input  logic     take,
  output logic     held_valid,
  output logic     held_level
);

  assign pin_ch.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pin_ch.valid && pin_ch.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pin_ch.valid && pin_ch.ready) begin
      held_level <= pin_ch.pin_level;
    end
  end

endmodule

>>> rtl/core/spfr_core.sv
// Hunt and frame sampling state with its per-tick update logic.
module spfr_core #(
  parameter int TIME_WIDTH = spfr_pkg::TIME_WIDTH_DEF,
  parameter int MAX_FRAME_BITS = spfr_pkg::MAX_FRAME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  spfr_pkg::cfg_t   cfg,
  input  logic             held_valid,
  input  logic             held_level,
  input  logic             out_free,
  output logic             take,
  output logic             res_load,
  output spfr_pkg::res_t   res
);

  localparam int CW = (TIME_WIDTH > spfr_pkg::REG_W) ? TIME_WIDTH : spfr_pkg::REG_W;
  localparam int BW = (MAX_FRAME_BITS > 1) ? $clog2(MAX_FRAME_BITS) : 1;
  localparam int FB_W = spfr_pkg::FB_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
  localparam logic [FB_W-1:0] FB_MAX = FB_W'(MAX_FRAME_BITS);

  spfr_pkg::phase_t phase, phase_next;
  logic                    prior_valid;
  logic                    prior_lvl;
  logic                    rise_seen;
  logic [TIME_WIDTH-1:0]   pulse_ticks;
  logic [TIME_WIDTH-1:0]   hunt_ticks;
  logic [spfr_pkg::REG_W-1:0] countdown;
  logic [BW-1:0]           bits_taken;
  logic                    ps_valid;
  logic                    ps_lvl;

  logic                  rising, falling;
  logic [TIME_WIDTH-1:0] pulse_upd, hunt_upd;
  logic [CW-1:0]         pulse_ext, len_ext, diff;
  logic                  sync_hit, timeout_hit;
  logic                  cd_wait;
  logic [FB_W-1:0]       nbits;
  logic [FB_W:0]         idx_plus;
  logic                  last;
  logic                  has_res;

  assign rising  = prior_valid && !prior_lvl && held_level;
  assign falling = prior_valid && prior_lvl && !held_level && rise_seen;

  always_comb begin
    if (rising) begin
      pulse_upd = '0;
    end else if (rise_seen && pulse_ticks != TIME_MAX) begin
      pulse_upd = pulse_ticks + TIME_WIDTH'(1);
    end else begin
      pulse_upd = pulse_ticks;
    end
  end

  assign hunt_upd  = (hunt_ticks == TIME_MAX) ? hunt_ticks : hunt_ticks + TIME_WIDTH'(1);
  assign pulse_ext = CW'(pulse_upd);
  assign len_ext   = CW'(cfg.sync_length);
  assign diff      = (pulse_ext > len_ext) ? pulse_ext - len_ext : len_ext - pulse_ext;
  assign sync_hit  = falling && (diff < CW'(cfg.sync_margin));
  assign timeout_hit = CW'(hunt_upd) >= CW'(cfg.hunt_timeout);

  assign cd_wait = countdown > spfr_pkg::REG_W'(1);

  always_comb begin
    if (cfg.frame_bits == '0) begin
      nbits = FB_W'(1);
    end else if (cfg.frame_bits > FB_MAX) begin
      nbits = FB_MAX;
    end else begin
      nbits = cfg.frame_bits;
    end
  end

  assign idx_plus = (FB_W + 1)'(bits_taken) + (FB_W + 1)'(1);
  assign last     = idx_plus >= {1'b0, nbits};

  assign has_res  = (phase == spfr_pkg::PH_HUNT) ? (sync_hit || timeout_hit) : !cd_wait;
  assign take     = held_valid && (!has_res || out_free);
  assign res_load = take && has_res;

  // next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        spfr_pkg::PH_HUNT: begin
          if (sync_hit) phase_next = spfr_pkg::PH_FRAME;
        end
        spfr_pkg::PH_FRAME: begin
          if (!cd_wait && last) phase_next = spfr_pkg::PH_HUNT;
        end
        default: phase_next = spfr_pkg::PH_HUNT;
      endcase
    end
  end

  // result word
  always_comb begin
    res = '0;
    unique case (phase)
      spfr_pkg::PH_HUNT: begin
        res.event_res = sync_hit ? spfr_pkg::EV_SYNC : spfr_pkg::EV_TIMEOUT;
      end
      spfr_pkg::PH_FRAME: begin
        res.event_res      = spfr_pkg::EV_BIT;
        res.bit_value      = held_level;
        res.repeated_level = ps_valid && (ps_lvl == held_level);
        res.bit_index      = FB_W'(bits_taken);
        res.frame_end      = last;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= spfr_pkg::PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_valid <= 1'b0;
      prior_lvl   <= 1'b0;
      rise_seen   <= 1'b0;
      pulse_ticks <= '0;
      hunt_ticks  <= '0;
      countdown   <= '0;
      bits_taken  <= '0;
      ps_valid    <= 1'b0;
      ps_lvl      <= 1'b0;
    end else if (take) begin
      if (phase == spfr_pkg::PH_HUNT) begin
        if (!sync_hit && timeout_hit) begin
          prior_valid <= 1'b0;
          rise_seen   <= 1'b0;
          pulse_ticks <= '0;
          hunt_ticks  <= '0;
          countdown   <= '0;
          bits_taken  <= '0;
          ps_valid    <= 1'b0;
        end else begin
          prior_valid <= 1'b1;
          prior_lvl   <= held_level;
          if (rising) rise_seen <= 1'b1;
          pulse_ticks <= pulse_upd;
          hunt_ticks  <= hunt_upd;
          if (sync_hit) begin
            countdown  <= cfg.first_delay;
            bits_taken <= '0;
            ps_valid   <= 1'b0;
          end
        end
      end else if (cd_wait) begin
        countdown <= countdown - spfr_pkg::REG_W'(1);
      end else if (last) begin
        // frame done: re-arm hunting
        prior_valid <= 1'b0;
        rise_seen   <= 1'b0;
        pulse_ticks <= '0;
        hunt_ticks  <= '0;
        countdown   <= '0;
        bits_taken  <= '0;
        ps_valid    <= 1'b0;
      end else begin
        ps_valid   <= 1'b1;
        ps_lvl     <= held_level;
        bits_taken <= bits_taken + BW'(1);
        countdown  <= cfg.bit_interval;
      end
    end
  end

endmodule

>>> rtl/core/spfr_out_stage.sv
// Result register driving the result channel.
module spfr_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  spfr_pkg::res_t  res,
  output logic            out_free,
  spfr_out_if.source      res_ch
);

  spfr_pkg::res_t held;

  assign out_free = !res_ch.valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (load) begin
      res_ch.valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign res_ch.event_res      = held.event_res;
  assign res_ch.bit_value      = held.bit_value;
  assign res_ch.repeated_level = held.repeated_level;
  assign res_ch.bit_index      = held.bit_index;
  assign res_ch.frame_end      = held.frame_end;

endmodule

>>> rtl/core/sync_pulse_frame_receiver.sv
// Sync-pulse frame receiver top level.
// Takes one line level word per clock, one per timebase tick, and hunts for a
// high sync pulse of the programmed width; after sync it samples the line at
// the programmed delay and interval and reports each bit, or reports a hunt
// timeout. One word is accepted every clock while the input side does not stall:
// the whole per-tick update is a single pass of counter and compare logic
// between the input register and the result register, so a word is registered
// in the input register and any result it gives then in the result register.
// The input side stalls only while a result is waiting and the result register
// is still full. Registers are written through cfg_we/cfg_index/cfg_data and
// should only be changed while the receiver is idle.
module sync_pulse_frame_receiver #(
  parameter int TIME_WIDTH = spfr_pkg::TIME_WIDTH_DEF,
  parameter int MAX_FRAME_BITS = spfr_pkg::MAX_FRAME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spfr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [spfr_pkg::REG_W-1:0]    cfg_data,
  spfr_in_if.sink                       pin_ch,
  spfr_out_if.source                    res_ch
);

  spfr_pkg::cfg_t cfg;
  spfr_pkg::res_t res;
  logic held_valid, held_level, take, res_load, out_free;

  spfr_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  spfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .pin_ch     (pin_ch),
    .take       (take),
    .held_valid (held_valid),
    .held_level (held_level)
  );

  spfr_core #(
    .TIME_WIDTH     (TIME_WIDTH),
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_level (held_level),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  spfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .out_free (out_free),
    .res_ch   (res_ch)
  );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the sync-pulse frame receiver with a per-tick predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_PHASES = 8;
  localparam logic [spfr_pkg::IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [spfr_pkg::IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [1:0] LVL_UNSET = 2'd2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [spfr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [spfr_pkg::REG_W-1:0] cfg_data = '0;

  spfr_in_if pin_ch ();
  spfr_out_if res_ch ();

  sync_pulse_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pin_ch    (pin_ch),
    .res_ch    (res_ch)
  );

  always #2 clk = ~clk;

  // receiver model state
  spfr_pkg::cfg_t regs;
  spfr_pkg::phase_t rx_phase;
  logic [1:0] last_lvl;
  logic [1:0] last_sample;
  logic rise_seen;
  logic [spfr_pkg::REG_W-1:0] pulse_cnt;
  logic [spfr_pkg::REG_W-1:0] hunt_cnt;
  logic [spfr_pkg::REG_W-1:0] countdown;
  logic [spfr_pkg::FB_W-1:0] bits_taken;

  logic level_q[$];
  spfr_pkg::res_t event_q[$];

  int err_cnt = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [spfr_pkg::REG_W-1:0] sat_inc(
      input logic [spfr_pkg::REG_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic rearm_hunt();
    rx_phase = spfr_pkg::PH_HUNT;
    last_lvl = LVL_UNSET;
    rise_seen = 1'b0;
    pulse_cnt = '0;
    hunt_cnt = '0;
    countdown = '0;
    bits_taken = '0;
    last_sample = LVL_UNSET;
  endtask

  task automatic push_event(input spfr_pkg::ev_code_t ev, input logic bval,
                            input logic rep, input logic [spfr_pkg::FB_W-1:0] idx,
                            input logic fend);
    spfr_pkg::res_t r;
    r.event_res = ev;
    r.bit_value = bval;
    r.repeated_level = rep;
    r.bit_index = idx;
    r.frame_end = fend;
    event_q.push_back(r);
  endtask

  // one timebase tick of the receiver
  task automatic track_tick(input logic lvl);
    logic sync;
    logic [spfr_pkg::REG_W-1:0] delta_w;
    logic [8:0] nbits;
    logic last;
    if (rx_phase == spfr_pkg::PH_HUNT) begin
      sync = 1'b0;
      if (last_lvl == 2'd0 && lvl == 1'b1) begin
        rise_seen = 1'b1;
        pulse_cnt = '0;
      end else if (rise_seen) begin
        pulse_cnt = sat_inc(pulse_cnt);
      end
      if (last_lvl == 2'd1 && lvl == 1'b0 && rise_seen) begin
        delta_w = (pulse_cnt > regs.sync_length) ? pulse_cnt - regs.sync_length
                                                 : regs.sync_length - pulse_cnt;
        sync = delta_w < regs.sync_margin;
      end
      last_lvl = {1'b0, lvl};
      hunt_cnt = sat_inc(hunt_cnt);
      if (sync) begin
        rx_phase = spfr_pkg::PH_FRAME;
        countdown = regs.first_delay;
        bits_taken = '0;
        last_sample = LVL_UNSET;
        push_event(spfr_pkg::EV_SYNC, 1'b0, 1'b0, '0, 1'b0);
      end else if (hunt_cnt >= regs.hunt_timeout) begin
        rearm_hunt();
        push_event(spfr_pkg::EV_TIMEOUT, 1'b0, 1'b0, '0, 1'b0);
      end
    end else if (countdown > 1) begin
      countdown = countdown - 1'b1;
    end else begin
      nbits = (regs.frame_bits == '0) ? 9'd1 : {1'b0, regs.frame_bits};
      last = ({1'b0, bits_taken} + 9'd1) >= nbits;
      push_event(spfr_pkg::EV_BIT, lvl, last_sample == {1'b0, lvl}, bits_taken, last);
      if (last) begin
        rearm_hunt();
      end else begin
        last_sample = {1'b0, lvl};
        bits_taken = bits_taken + 1'b1;
        countdown = regs.bit_interval;
      end
    end
  endtask

  task automatic write_reg(input logic [spfr_pkg::IDX_W-1:0] idx,
                           input logic [spfr_pkg::REG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      spfr_pkg::CFG_SYNC_LENGTH: regs.sync_length = data;
      spfr_pkg::CFG_SYNC_MARGIN: regs.sync_margin = data;
      spfr_pkg::CFG_FIRST_DELAY: regs.first_delay = data;
      spfr_pkg::CFG_BIT_INTERVAL: regs.bit_interval = data;
      spfr_pkg::CFG_FRAME_BITS: regs.frame_bits = data[spfr_pkg::FB_W-1:0];
      spfr_pkg::CFG_HUNT_TIMEOUT: regs.hunt_timeout = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [spfr_pkg::REG_W-1:0] len,
                              input logic [spfr_pkg::REG_W-1:0] mrg,
                              input logic [spfr_pkg::REG_W-1:0] fd,
                              input logic [spfr_pkg::REG_W-1:0] bi,
                              input logic [spfr_pkg::REG_W-1:0] fb_word,
                              input logic [spfr_pkg::REG_W-1:0] to);
    write_reg(spfr_pkg::CFG_SYNC_LENGTH, len);
    write_reg(spfr_pkg::CFG_SYNC_MARGIN, mrg);
    write_reg(spfr_pkg::CFG_FIRST_DELAY, fd);
    write_reg(spfr_pkg::CFG_BIT_INTERVAL, bi);
    write_reg(spfr_pkg::CFG_FRAME_BITS, fb_word);
    write_reg(spfr_pkg::CFG_HUNT_TIMEOUT, to);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_bits(input logic [31:0] pattern, input int n);
    for (int i = n - 1; i >= 0; i--) level_q.push_back(pattern[i]);
  endtask

  task automatic add_run(input logic lvl, input int n);
    repeat (n) level_q.push_back(lvl);
  endtask

  // wait until every word is taken, every result is in and the pipe is empty
  task automatic drain();
    do @(negedge clk); while (level_q.size() != 0 || pin_ch.valid);
    while (event_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // mostly sync pulses near the programmed width followed by a frame's worth of
  // random data, the rest noise and long low runs
  task automatic gen_phase(input int count);
    int len, mrg, fd, bi, nb, to, dev, hi, body, pick;
    len = int'(regs.sync_length);
    mrg = (regs.sync_margin > 6) ? 6 : int'(regs.sync_margin);
    fd = (regs.first_delay == '0) ? 1 : int'(regs.first_delay);
    bi = (regs.bit_interval == '0) ? 1 : int'(regs.bit_interval);
    nb = (regs.frame_bits == '0) ? 1 : int'(regs.frame_bits);
    to = int'(regs.hunt_timeout);
    while (level_q.size() < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        add_run(1'b0, $urandom_range(1, 3));
        dev = int'($urandom_range(0, 2 * mrg + 2)) - (mrg + 1);
        hi = len + dev;
        if (hi < 1) hi = 1;
        if (hi > 30) hi = $urandom_range(20, 30);
        add_run(1'b1, hi);
        add_run(1'b0, 1);
        body = (fd > 60 || bi > 60) ? 60 : fd + (nb - 1) * bi;
        if (body > 60) body = 60;
        repeat (body) level_q.push_back(1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 10)) level_q.push_back(1'($urandom_range(0, 1)));
      end else begin
        add_run(1'b0, ((to < 60) ? to : int'($urandom_range(20, 60))) + 1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pin_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (pin_ch.valid && pin_ch.ready) track_tick(pin_ch.pin_level);
      if (!pin_ch.valid || pin_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          pin_ch.valid <= 1'b0;
        end else if (level_q.size() != 0) begin
          pin_ch.valid <= 1'b1;
          pin_ch.pin_level <= level_q.pop_front();
          in_gap <= pick_gap();
        end else begin
          pin_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : b_monitor
    spfr_pkg::res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
      out_gap <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (event_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected word: ev=%0d bit=%0b rep=%0b idx=%0d end=%0b",
                     res_ch.event_res, res_ch.bit_value, res_ch.repeated_level,
                     res_ch.bit_index, res_ch.frame_end);
        end else begin
          want = event_q.pop_front();
          if (res_ch.event_res !== want.event_res || res_ch.bit_value !== want.bit_value ||
              res_ch.repeated_level !== want.repeated_level ||
              res_ch.bit_index !== want.bit_index || res_ch.frame_end !== want.frame_end) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch ev/bit/rep/idx/end: exp %0d/%0b/%0b/%0d/%0b got %0d/%0b/%0b/%0d/%0b",
                       want.event_res, want.bit_value, want.repeated_level,
                       want.bit_index, want.frame_end, res_ch.event_res,
                       res_ch.bit_value, res_ch.repeated_level, res_ch.bit_index,
                       res_ch.frame_end);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_seen != hold_req || (!no_idle && $urandom_range(0, 499) == 0)) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((pin_ch.valid && pin_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : b_stim
    int count;
    pin_ch.valid = 1'b0;
    pin_ch.pin_level = 1'b0;
    res_ch.ready = 1'b0;
    regs.sync_length = spfr_pkg::SYNC_LENGTH_RST;
    regs.sync_margin = spfr_pkg::SYNC_MARGIN_RST;
    regs.first_delay = spfr_pkg::FIRST_DELAY_RST;
    regs.bit_interval = spfr_pkg::BIT_INTERVAL_RST;
    regs.frame_bits = spfr_pkg::FRAME_BITS_RST;
    regs.hunt_timeout = spfr_pkg::HUNT_TIMEOUT_RST;
    rearm_hunt();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // first tick high, stray fall, sync on the timeout tick, one-bit frame, timeout
    program_regs(24'd2, 24'd1, 24'd0, 24'd0, 24'h000000, 24'd5);
    push_bits(32'b10110100000, 11);
    drain();

    // zero timeout: every hunting tick gives up
    program_regs(24'd1, 24'd2, 24'd2, 24'd1, 24'h5A5A03, 24'd0);
    push_bits(32'b101, 3);
    drain();

    // unused indexes are written, but every register is programmed again after them
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 24'h000000);
    program_regs(24'd1, 24'd2, 24'd2, 24'd1, 24'hA5A503, 24'd100);
    push_bits(32'b0101110, 7);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1: program_regs(24'($urandom_range(1, 8)), '1, 24'($urandom_range(0, 3)),
                        24'd0, '1, 24'($urandom_range(40, 150)));
        2: program_regs('1, '1, 24'($urandom_range(0, 3)), 24'($urandom_range(1, 3)),
                        {16'($urandom), 8'($urandom_range(1, 8))}, '1);
        3: program_regs(24'($urandom_range(1, 10)), 24'd0, '1, '1,
                        {16'($urandom), 8'($urandom_range(0, 12))},
                        24'($urandom_range(1, 40)));
        4: program_regs(24'd1, 24'd1, 24'd0, 24'd0, 24'($urandom_range(1, 4)), 24'd1);
        default: program_regs(24'($urandom_range(1, 12)), 24'($urandom_range(0, 4)),
                              24'($urandom_range(0, 6)), 24'($urandom_range(0, 4)),
                              {16'($urandom), 8'($urandom_range(0, 12))},
                              24'($urandom_range(1, 150)));
      endcase
      no_idle = (p % 3 == 2);
      count = (p == 1) ? 200 : 45;
      gen_phase(count);
      if (p == 1 || p == 4) begin
        while (level_q.size() > count / 2) @(negedge clk);
        hold_req++;
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (err_cnt == 0 && event_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
